// ===== sv/pel_pkg.sv =====
// ----------------------------------------------------------------------------
// pel_pkg
// Shared types, codes and sizes of the positional insert/erase list.
// ----------------------------------------------------------------------------
`default_nettype none

package pel_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 64;

    localparam int WORD_W = 64;
    localparam int POS_W  = 5;
    localparam int END_W  = 4;
    localparam int OUT_CNT_W = 5;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(DEPTH);

    typedef logic [DATA_WIDTH-1:0] word_t;
    typedef logic [CNT_W-1:0]      count_t;
    typedef logic [IDX_W-1:0]      idx_t;

    typedef enum logic [2:0] {
        OP_PUSH        = 3'd0,
        OP_POP         = 3'd1,
        OP_READ        = 3'd2,
        OP_INSERT      = 3'd3,
        OP_ERASE       = 3'd4,
        OP_ERASE_RANGE = 3'd5,
        OP_FRONT       = 3'd6,
        OP_BACK        = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    // Per-cell command: hold, take the new word, take the lower neighbor
    // (shift up) or take the upper neighbor (shift down).
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_UP,
        CELL_DOWN
    } cell_cmd_t;

    typedef enum logic [1:0] {
        ROW_HOLD,
        ROW_INSERT,
        ROW_ERASE
    } row_act_t;

    typedef struct packed {
        row_act_t act;
        idx_t     pos;
    } row_ctl_t;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        idx_t    rd_idx;
        status_t status;
        count_t  count;
    } res_t;

    typedef struct packed {
        op_t               operation;
        logic [POS_W-1:0]  position;
        logic [END_W-1:0]  position_end;
        logic [WORD_W-1:0] value;
    } cmd_item_t;

    typedef struct packed {
        logic [WORD_W-1:0]    read_value;
        status_t              status;
        logic [OUT_CNT_W-1:0] count;
    } rsp_item_t;

endpackage

`default_nettype wire

// ===== sv/pel_cmd_if.sv =====
// ----------------------------------------------------------------------------
// pel_cmd_if
// Valid/ready channel that carries one list operation per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface pel_cmd_if;
    logic               valid;
    logic               ready;
    pel_pkg::cmd_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/pel_rsp_if.sv =====
// ----------------------------------------------------------------------------
// pel_rsp_if
// Valid/ready channel that carries one operation result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface pel_rsp_if;
    logic               valid;
    logic               ready;
    pel_pkg::rsp_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/pel_cell.sv =====
// ----------------------------------------------------------------------------
// pel_cell
// One storage slot of the list; loads, holds or shifts from a neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module pel_cell (
    input  wire logic               clk,
    input  wire pel_pkg::cell_cmd_t cell_cmd,
    input  wire pel_pkg::word_t     load_word,
    input  wire pel_pkg::word_t     lower_word,
    input  wire pel_pkg::word_t     upper_word,
    output pel_pkg::word_t          word
);

    pel_pkg::word_t word_reg;
    pel_pkg::word_t word_next;

    always_comb
    begin
        unique case (cell_cmd)
            pel_pkg::CELL_LOAD: word_next = load_word;
            pel_pkg::CELL_UP:   word_next = lower_word;
            pel_pkg::CELL_DOWN: word_next = upper_word;
            default:            word_next = word_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

`default_nettype wire

// ===== sv/pel_ctrl.sv =====
// ----------------------------------------------------------------------------
// pel_ctrl
// Decode operations, track the element count, sequence range erases.
// ----------------------------------------------------------------------------
`default_nettype none

module pel_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire pel_pkg::cmd_item_t item,
    input  wire logic               out_free,
    output logic                    in_ready,
    output pel_pkg::row_ctl_t       row,
    output pel_pkg::res_t           res
);

    typedef enum logic {
        S_IDLE,
        S_ERASE
    } state_t;

    state_t               state_reg, state_next;
    pel_pkg::count_t      count_reg, count_next;
    pel_pkg::count_t      left_reg, left_next;
    pel_pkg::idx_t        pos_reg, pos_next;

    logic                        accept;
    logic [pel_pkg::CMP_W-1:0]   pos_c;
    logic [pel_pkg::CMP_W-1:0]   end_c;
    logic [pel_pkg::CMP_W-1:0]   cnt_c;

    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign accept   = in_valid && in_ready;

    assign pos_c = pel_pkg::CMP_W'(item.position);
    assign end_c = pel_pkg::CMP_W'(item.position_end);
    assign cnt_c = pel_pkg::CMP_W'(count_reg);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        left_next  = left_reg;
        pos_next   = pos_reg;
        row        = '{act: pel_pkg::ROW_HOLD, pos: '0};
        res        = '{load: 1'b0, rd_en: 1'b0, rd_idx: '0,
                       status: pel_pkg::ST_OK, count: count_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res.load = 1'b1;
                    unique case (item.operation)
                        pel_pkg::OP_PUSH:
                        begin
                            if (count_reg == pel_pkg::COUNT_FULL)
                            begin
                                res.status = pel_pkg::ST_FULL;
                            end
                            else
                            begin
                                row        = '{act: pel_pkg::ROW_INSERT,
                                               pos: pel_pkg::IDX_W'(count_reg)};
                                count_next = count_reg + 1'b1;
                            end
                        end
                        pel_pkg::OP_POP:
                        begin
                            if (count_reg == '0)
                                res.status = pel_pkg::ST_EMPTY;
                            else
                                count_next = count_reg - 1'b1;
                        end
                        pel_pkg::OP_READ:
                        begin
                            if (pos_c >= cnt_c)
                            begin
                                res.status = pel_pkg::ST_RANGE;
                            end
                            else
                            begin
                                res.rd_en  = 1'b1;
                                res.rd_idx = pel_pkg::IDX_W'(item.position);
                            end
                        end
                        pel_pkg::OP_INSERT:
                        begin
                            if (count_reg == pel_pkg::COUNT_FULL)
                            begin
                                res.status = pel_pkg::ST_FULL;
                            end
                            else if (pos_c > cnt_c)
                            begin
                                res.status = pel_pkg::ST_RANGE;
                            end
                            else
                            begin
                                row        = '{act: pel_pkg::ROW_INSERT,
                                               pos: pel_pkg::IDX_W'(item.position)};
                                count_next = count_reg + 1'b1;
                            end
                        end
                        pel_pkg::OP_ERASE:
                        begin
                            if (pos_c >= cnt_c)
                            begin
                                res.status = pel_pkg::ST_RANGE;
                            end
                            else
                            begin
                                row        = '{act: pel_pkg::ROW_ERASE,
                                               pos: pel_pkg::IDX_W'(item.position)};
                                count_next = count_reg - 1'b1;
                            end
                        end
                        pel_pkg::OP_ERASE_RANGE:
                        begin
                            if (pos_c >= cnt_c || end_c >= cnt_c || end_c < pos_c)
                            begin
                                res.status = pel_pkg::ST_RANGE;
                            end
                            else
                            begin
                                // First shift now; one more per remaining entry.
                                row        = '{act: pel_pkg::ROW_ERASE,
                                               pos: pel_pkg::IDX_W'(item.position)};
                                count_next = count_reg - 1'b1;
                                left_next  = pel_pkg::CNT_W'(end_c - pos_c);
                                pos_next   = pel_pkg::IDX_W'(item.position);
                                if (end_c != pos_c)
                                begin
                                    res.load   = 1'b0;
                                    state_next = S_ERASE;
                                end
                            end
                        end
                        pel_pkg::OP_FRONT:
                        begin
                            if (count_reg == '0)
                            begin
                                res.status = pel_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                res.rd_en  = 1'b1;
                                res.rd_idx = '0;
                            end
                        end
                        pel_pkg::OP_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                res.status = pel_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                res.rd_en  = 1'b1;
                                res.rd_idx = pel_pkg::IDX_W'(count_reg - 1'b1);
                            end
                        end
                        default:
                        begin
                            res.status = pel_pkg::ST_OK;
                        end
                    endcase
                    res.count = count_next;
                end
            end
            S_ERASE:
            begin
                row        = '{act: pel_pkg::ROW_ERASE, pos: pos_reg};
                count_next = count_reg - 1'b1;
                left_next  = left_reg - 1'b1;
                if (left_reg == pel_pkg::CNT_W'(1))
                begin
                    res.load   = 1'b1;
                    state_next = S_IDLE;
                end
                res.count = count_next;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            left_reg  <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            left_reg  <= left_next;
            pos_reg   <= pos_next;
        end
    end

    a_erase_blocks_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_ERASE) |-> !in_ready
    ) else $error("input taken during a range erase");

    a_erase_step_count: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_ERASE) |=> (count_reg == $past(count_reg) - 1'b1)
    ) else $error("range erase step did not drop the count by one");

    a_push_grows: assert property (
        @(posedge clk) disable iff (!rst_n)
        (accept && item.operation == pel_pkg::OP_PUSH && count_reg != pel_pkg::COUNT_FULL)
        |=> (count_reg == $past(count_reg) + 1'b1)
    ) else $error("push did not grow the count");

endmodule

`default_nettype wire

// ===== sv/positional_insert_erase_list.sv =====
// ----------------------------------------------------------------------------
// positional_insert_erase_list
// Fixed-capacity ordered list of words with push, pop, indexed read, insert,
// erase and range erase, built as a row of shifting storage cells.
// ----------------------------------------------------------------------------
// Result: the result beat of each operation is registered; a range erase
//   removes its entries one shift per cycle and loads its result with the last shift.
// Throughput: one operation per cycle for all other operations, as long as
//   the result register is empty or drains in the same cycle.
// Reset: clears the element count and the result valid; cell contents are
//   left undefined and are only read after they have been written.
`default_nettype none

module positional_insert_erase_list (
    input  wire logic clk,
    input  wire logic rst_n,
    pel_cmd_if.sink   cmd,
    pel_rsp_if.source rsp
);

    // Control path: decode, count tracking and range-erase sequencing.
    pel_pkg::row_ctl_t row;
    pel_pkg::res_t     res;
    logic              out_free;

    // Result register: free when empty or being drained this cycle.
    logic               rsp_valid_reg, rsp_valid_next;
    pel_pkg::rsp_item_t rsp_item_reg, rsp_item_next;

    pel_pkg::word_t cell_word [pel_pkg::DEPTH];
    pel_pkg::word_t store_word;
    pel_pkg::word_t rd_word;

    assign out_free   = !rsp_valid_reg || rsp.ready;
    assign store_word = cmd.data.value[pel_pkg::DATA_WIDTH-1:0];

    pel_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .item     (cmd.data),
        .out_free (out_free),
        .in_ready (cmd.ready),
        .row      (row),
        .res      (res)
    );

    // Row of cells: every cell compares its own index with the broadcast
    // position. Insert loads at the position and shifts everything above it
    // up by one; erase shifts the position and everything above it down.
    for (genvar i = 0; i < pel_pkg::DEPTH; i++)
    begin : g_cell
        localparam logic [pel_pkg::IDX_W-1:0] CELL_IDX = pel_pkg::IDX_W'(i);

        pel_pkg::cell_cmd_t cell_cmd;
        pel_pkg::word_t     lower_w;
        pel_pkg::word_t     upper_w;

        always_comb
        begin
            unique case (row.act)
                pel_pkg::ROW_INSERT:
                begin
                    if (CELL_IDX == row.pos)
                        cell_cmd = pel_pkg::CELL_LOAD;
                    else if (CELL_IDX > row.pos)
                        cell_cmd = pel_pkg::CELL_UP;
                    else
                        cell_cmd = pel_pkg::CELL_HOLD;
                end
                pel_pkg::ROW_ERASE:
                begin
                    if (CELL_IDX >= row.pos)
                        cell_cmd = pel_pkg::CELL_DOWN;
                    else
                        cell_cmd = pel_pkg::CELL_HOLD;
                end
                default:
                begin
                    cell_cmd = pel_pkg::CELL_HOLD;
                end
            endcase
        end

        // The bottom cell never shifts up, the top cell takes its own word
        // on a shift down (the slot above the count is don't-care).
        if (i == 0)
        begin : g_bottom
            assign lower_w = store_word;
        end
        else
        begin : g_lower
            assign lower_w = cell_word[i-1];
        end

        if (i == pel_pkg::DEPTH - 1)
        begin : g_top
            assign upper_w = cell_word[i];
        end
        else
        begin : g_upper
            assign upper_w = cell_word[i+1];
        end

        pel_cell u_cell (
            .clk        (clk),
            .cell_cmd   (cell_cmd),
            .load_word  (store_word),
            .lower_word (lower_w),
            .upper_word (upper_w),
            .word       (cell_word[i])
        );
    end

    // Read port: reads happen before any shift of the same beat.
    assign rd_word = cell_word[res.rd_idx];

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_item_next  = rsp_item_reg;
        if (rsp.ready)
            rsp_valid_next = 1'b0;
        if (res.load)
        begin
            rsp_valid_next           = 1'b1;
            rsp_item_next.read_value = res.rd_en ? pel_pkg::WORD_W'(rd_word) : '0;
            rsp_item_next.status     = res.status;
            rsp_item_next.count      = pel_pkg::OUT_CNT_W'(res.count);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else
            rsp_valid_reg <= rsp_valid_next;
    end

    always_ff @(posedge clk)
    begin
        rsp_item_reg <= rsp_item_next;
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_item_reg;

    // Never overwrite a result beat that has not been taken.
    a_no_overwrite: assert property (
        @(posedge clk) disable iff (!rst_n)
        res.load |-> out_free
    ) else $error("result register overwritten while still pending");

endmodule

`default_nettype wire
